// File: rtl/core/rbdq_pkg.sv
// Shared types and constants for the ring-buffer deque core.
// Used by rbdq_ctrl, rbdq_dp and ring_buffer_deque_with_search_core.
`default_nettype none

package rbdq_pkg;

    localparam int DEPTH_DEFAULT      = 64;
    localparam int DATA_WIDTH_DEFAULT = 32;

    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;
    localparam int CAP_W    = 7;
    localparam int CAP_RESET = 64;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 48;
    localparam int S_TUSER_W = 8;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_REAR  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_REAR   = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_PEEK_REAR  = 3'd5,
        OP_FIND       = 3'd6,
        OP_CLEAR      = 3'd7
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_FIND = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic capture_read;
        logic find_step;
        logic load_out;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic empty;
        logic match;
        logic last;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/core/rbdq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rbdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/core/rbdq_ctrl.sv
// Sequencing FSM for the deque: accept, memory read wait, find walk, result hand-off.
// Depends on rbdq_pkg.
`default_nettype none

module rbdq_ctrl (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    input  wire rbdq_pkg::op_t                     in_op,
    input  wire rbdq_pkg::dp_status_t              dp_status,
    output logic                                   in_ready,
    output rbdq_pkg::ctrl_cmd_t                    cmd
);

    rbdq_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rbdq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        cmd              = '0;
        in_ready         = 1'b0;
        case (state_reg)
            rbdq_pkg::S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    case (in_op)
                        rbdq_pkg::OP_POP_FRONT,
                        rbdq_pkg::OP_POP_REAR,
                        rbdq_pkg::OP_PEEK_FRONT,
                        rbdq_pkg::OP_PEEK_REAR:
                            state_next = dp_status.empty ? rbdq_pkg::S_DONE
                                                         : rbdq_pkg::S_READ;
                        rbdq_pkg::OP_FIND:
                            state_next = dp_status.empty ? rbdq_pkg::S_DONE
                                                         : rbdq_pkg::S_FIND;
                        default:
                            state_next = rbdq_pkg::S_DONE;
                    endcase
                end
            end
            rbdq_pkg::S_READ:
            begin
                cmd.capture_read = 1'b1;
                state_next       = rbdq_pkg::S_DONE;
            end
            rbdq_pkg::S_FIND:
            begin
                cmd.find_step = 1'b1;
                if (dp_status.match || dp_status.last)
                begin
                    state_next = rbdq_pkg::S_DONE;
                end
            end
            rbdq_pkg::S_DONE:
            begin
                if (dp_status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = rbdq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rbdq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/rbdq_dp.sv
// Deque datapath: ring pointers, fill count, capacity, entry RAM, result and output registers.
// Depends on rbdq_pkg and rbdq_ram.
`default_nettype none

module rbdq_dp #(
    parameter int DEPTH      = rbdq_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = rbdq_pkg::DATA_WIDTH_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire rbdq_pkg::ctrl_cmd_t               cmd,
    input  wire rbdq_pkg::op_t                     in_op,
    input  wire logic [rbdq_pkg::VALUE_W-1:0]      in_value,
    input  wire logic                              cfg_we,
    input  wire logic [rbdq_pkg::CAP_W-1:0]        cfg_wdata,
    input  wire logic                              out_ready,
    output rbdq_pkg::dp_status_t                   dp_status,
    output logic                                   out_valid,
    output logic [rbdq_pkg::VALUE_W-1:0]           out_value,
    output logic [rbdq_pkg::POS_W-1:0]             out_pos,
    output rbdq_pkg::status_t                      out_status,
    output logic [rbdq_pkg::COUNT_W-1:0]           out_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = AW + 1;
    localparam int CAP_RST = (rbdq_pkg::CAP_RESET > DEPTH) ? DEPTH : rbdq_pkg::CAP_RESET;

    logic [AW-1:0]         head_reg, head_next;
    logic [AW-1:0]         tail_reg, tail_next;
    logic [CW-1:0]         fill_reg, fill_next;
    logic [CW-1:0]         cap_reg, cap_next;
    logic [AW-1:0]         walk_reg, walk_next;
    logic [AW-1:0]         cmp_pos_reg, cmp_pos_next;
    logic [DATA_WIDTH-1:0] key_reg, key_next;

    logic [rbdq_pkg::VALUE_W-1:0] res_value_reg, res_value_next;
    logic [AW-1:0]                res_pos_reg, res_pos_next;
    rbdq_pkg::status_t            res_status_reg, res_status_next;

    logic                         out_valid_reg;
    logic [rbdq_pkg::VALUE_W-1:0] out_value_reg;
    logic [rbdq_pkg::POS_W-1:0]   out_pos_reg;
    rbdq_pkg::status_t            out_status_reg;
    logic [rbdq_pkg::COUNT_W-1:0] out_count_reg;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [AW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;
    logic [DATA_WIDTH-1:0] in_data;
    logic                  is_full;
    logic                  is_empty;
    logic [AW-1:0]         head_prev;
    logic [AW-1:0]         head_succ;
    logic [AW-1:0]         tail_prev;
    logic [AW-1:0]         tail_succ;
    logic [AW-1:0]         walk_succ;
    logic [CW-1:0]         cmp_pos_inc;
    logic                  match;
    logic                  last;

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i,
                                                input logic [CW-1:0] cap);
        logic [CW-1:0] nx;
        nx = {1'b0, i} + CW'(1);
        return (nx >= cap) ? '0 : nx[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] i,
                                                input logic [CW-1:0] cap);
        logic [CW-1:0] lastidx;
        lastidx = cap - CW'(1);
        return (i == '0) ? lastidx[AW-1:0] : i - AW'(1);
    endfunction

    // low DATA_WIDTH bits of the input word, zero-extended if wider
    logic [DATA_WIDTH+rbdq_pkg::VALUE_W-1:0] in_wide;
    assign in_wide = {{DATA_WIDTH{1'b0}}, in_value};
    assign in_data = in_wide[DATA_WIDTH-1:0];

    logic [DATA_WIDTH+rbdq_pkg::VALUE_W-1:0] rd_wide;
    assign rd_wide = {{rbdq_pkg::VALUE_W{1'b0}}, ram_rdata};

    assign is_full     = (fill_reg >= cap_reg);
    assign is_empty    = (fill_reg == '0);
    assign head_prev   = ring_prev(head_reg, cap_reg);
    assign head_succ   = ring_next(head_reg, cap_reg);
    assign tail_prev   = ring_prev(tail_reg, cap_reg);
    assign tail_succ   = ring_next(tail_reg, cap_reg);
    assign walk_succ   = ring_next(walk_reg, cap_reg);
    assign cmp_pos_inc = {1'b0, cmp_pos_reg} + CW'(1);
    assign match       = (ram_rdata == key_reg);
    assign last        = (cmp_pos_inc == fill_reg);

    // write on a successful push
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = tail_reg;
        if (cmd.accept && !is_full)
        begin
            if (in_op == rbdq_pkg::OP_PUSH_FRONT)
            begin
                ram_we    = 1'b1;
                ram_waddr = head_prev;
            end
            else if (in_op == rbdq_pkg::OP_PUSH_REAR)
            begin
                ram_we = 1'b1;
            end
        end
    end

    // read address: walk pointer while searching, else the end that the op names
    always_comb
    begin
        if (cmd.find_step)
        begin
            ram_raddr = walk_reg;
        end
        else if (in_op == rbdq_pkg::OP_POP_REAR || in_op == rbdq_pkg::OP_PEEK_REAR)
        begin
            ram_raddr = tail_prev;
        end
        else
        begin
            ram_raddr = head_reg;
        end
    end

    rbdq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (in_data),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        fill_next       = fill_reg;
        cap_next        = cap_reg;
        walk_next       = walk_reg;
        cmp_pos_next    = cmp_pos_reg;
        key_next        = key_reg;
        res_value_next  = res_value_reg;
        res_pos_next    = res_pos_reg;
        res_status_next = res_status_reg;

        if (cfg_we)
        begin
            // zero acts as one, oversize clamps to DEPTH
            if (cfg_wdata == '0)
            begin
                cap_next = CW'(1);
            end
            else if (32'(cfg_wdata) > DEPTH)
            begin
                cap_next = CW'(DEPTH);
            end
            else
            begin
                cap_next = CW'(cfg_wdata);
            end
            head_next = '0;
            tail_next = '0;
            fill_next = '0;
        end
        else if (cmd.accept)
        begin
            res_value_next  = '0;
            res_pos_next    = '0;
            res_status_next = rbdq_pkg::ST_OK;
            case (in_op)
                rbdq_pkg::OP_PUSH_FRONT,
                rbdq_pkg::OP_PUSH_REAR:
                begin
                    if (is_full)
                    begin
                        res_status_next = rbdq_pkg::ST_FULL;
                    end
                    else
                    begin
                        fill_next = fill_reg + CW'(1);
                        if (in_op == rbdq_pkg::OP_PUSH_FRONT)
                        begin
                            head_next = head_prev;
                        end
                        else
                        begin
                            tail_next = tail_succ;
                        end
                    end
                end
                rbdq_pkg::OP_POP_FRONT,
                rbdq_pkg::OP_PEEK_FRONT:
                begin
                    if (is_empty)
                    begin
                        res_status_next = rbdq_pkg::ST_EMPTY;
                    end
                    else if (in_op == rbdq_pkg::OP_POP_FRONT)
                    begin
                        fill_next = fill_reg - CW'(1);
                        head_next = head_succ;
                    end
                end
                rbdq_pkg::OP_POP_REAR,
                rbdq_pkg::OP_PEEK_REAR:
                begin
                    if (is_empty)
                    begin
                        res_status_next = rbdq_pkg::ST_EMPTY;
                    end
                    else if (in_op == rbdq_pkg::OP_POP_REAR)
                    begin
                        fill_next = fill_reg - CW'(1);
                        tail_next = tail_prev;
                    end
                end
                rbdq_pkg::OP_FIND:
                begin
                    res_status_next = rbdq_pkg::ST_NOT_FOUND;
                    key_next        = in_data;
                    walk_next       = head_succ;
                    cmp_pos_next    = '0;
                end
                default:
                begin
                    head_next = '0;
                    tail_next = '0;
                    fill_next = '0;
                end
            endcase
        end
        else if (cmd.capture_read)
        begin
            res_value_next = rd_wide[rbdq_pkg::VALUE_W-1:0];
        end
        else if (cmd.find_step)
        begin
            // rdata holds the entry at cmp_pos; next one is already addressed
            if (match)
            begin
                res_status_next = rbdq_pkg::ST_OK;
                res_pos_next    = cmp_pos_reg;
            end
            cmp_pos_next = cmp_pos_inc[AW-1:0];
            walk_next    = walk_succ;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            cap_reg       <= CW'(CAP_RST);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
            cap_reg  <= cap_next;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    logic [AW+rbdq_pkg::POS_W-1:0]   pos_wide;
    logic [CW+rbdq_pkg::COUNT_W-1:0] count_wide;
    assign pos_wide   = {{rbdq_pkg::POS_W{1'b0}}, res_pos_reg};
    assign count_wide = {{rbdq_pkg::COUNT_W{1'b0}}, fill_reg};

    always_ff @(posedge clk)
    begin
        walk_reg       <= walk_next;
        cmp_pos_reg    <= cmp_pos_next;
        key_reg        <= key_next;
        res_value_reg  <= res_value_next;
        res_pos_reg    <= res_pos_next;
        res_status_reg <= res_status_next;
        if (cmd.load_out)
        begin
            out_value_reg  <= res_value_reg;
            out_pos_reg    <= pos_wide[rbdq_pkg::POS_W-1:0];
            out_status_reg <= res_status_reg;
            out_count_reg  <= count_wide[rbdq_pkg::COUNT_W-1:0];
        end
    end

    assign dp_status.empty    = is_empty;
    assign dp_status.match    = match;
    assign dp_status.last     = last;
    assign dp_status.out_free = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_value  = out_value_reg;
    assign out_pos    = out_pos_reg;
    assign out_status = out_status_reg;
    assign out_count  = out_count_reg;

endmodule

`default_nettype wire

// File: rtl/core/ring_buffer_deque_with_search_core.sv
// Deque in a circular RAM with push/pop/peek at both ends, find and clear.
// Push, clear, full push, empty pop/peek/find: IDLE then DONE; pop and peek also pass READ
// (registered RAM read); find walks one entry per cycle in FIND until a hit or the last entry.
// A result waits in an output register; the next beat is taken meanwhile, then DONE stalls.
// Reset (async, rst_n low): empty deque, capacity 64 (or DEPTH if smaller), no output;
// RAM is not cleared. Depends on rbdq_pkg, rbdq_ctrl, rbdq_dp, rbdq_ram.
`default_nettype none

module ring_buffer_deque_with_search_core #(
    parameter int DEPTH      = rbdq_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = rbdq_pkg::DATA_WIDTH_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    // input beats
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [rbdq_pkg::S_TDATA_W-1:0]    s_tdata,   // [31:0] value
    input  wire logic [rbdq_pkg::S_TUSER_W-1:0]    s_tuser,   // [2:0] op, [7:3] zero

    // result beats
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [31:0] result_value, [37:32] position, [39:38] status, [46:40] count, [47] zero
    output logic [rbdq_pkg::M_TDATA_W-1:0]         m_tdata,

    // capacity register
    input  wire logic                              cfg_we,
    input  wire logic [rbdq_pkg::CAP_W-1:0]        cfg_wdata
);

    rbdq_pkg::ctrl_cmd_t  cmd;
    rbdq_pkg::dp_status_t dp_status;
    rbdq_pkg::op_t        in_op;

    logic [rbdq_pkg::VALUE_W-1:0] out_value;
    logic [rbdq_pkg::POS_W-1:0]   out_pos;
    rbdq_pkg::status_t            out_status;
    logic [rbdq_pkg::COUNT_W-1:0] out_count;

    // upper tuser bits carry nothing
    assign in_op = rbdq_pkg::op_t'(s_tuser[rbdq_pkg::OP_W-1:0]);

    // FSM: IDLE takes a beat, READ waits on the RAM, FIND walks, DONE hands off
    rbdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_op     (in_op),
        .dp_status (dp_status),
        .in_ready  (s_tready),
        .cmd       (cmd)
    );

    rbdq_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .in_op      (in_op),
        .in_value   (s_tdata),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .out_ready  (m_tready),
        .dp_status  (dp_status),
        .out_valid  (m_tvalid),
        .out_value  (out_value),
        .out_pos    (out_pos),
        .out_status (out_status),
        .out_count  (out_count)
    );

    assign m_tdata = {1'b0, out_count, out_status, out_pos, out_value};

endmodule

`default_nettype wire
